### sv/bac_pkg.sv
// ----------------------------------------------------------------------------
// bac_pkg
// Shared types, codes and constants for the beacon acquisition controller.
// ----------------------------------------------------------------------------
`default_nettype none

package bac_pkg;

  localparam int unsigned TimeW     = 32;
  localparam int unsigned RetryW    = 31;
  localparam int unsigned MacW      = 3;
  localparam int unsigned StateCodeW = 3;
  localparam int unsigned CfgIndexW = 2;
  localparam int unsigned CfgDataW  = 32;

  localparam logic [TimeW-1:0]  SearchTimeoutReset = 32'd130000;
  localparam logic [RetryW-1:0] RetryIntervalReset = 31'd300000;

  // Configuration register indexes
  localparam logic [CfgIndexW-1:0] CFG_SEARCH_TIMEOUT = 2'd0;
  localparam logic [CfgIndexW-1:0] CFG_RETRY_INTERVAL = 2'd1;

  // Input operation codes
  localparam logic OP_TICK  = 1'b0;
  localparam logic OP_START = 1'b1;

  // MAC class-B phase codes
  localparam logic [MacW-1:0] MAC_FAILED    = 3'd3;
  localparam logic [MacW-1:0] MAC_COMPLETED = 3'd4;

  // Reported beacon state codes
  localparam logic [StateCodeW-1:0] BS_IDLE      = 3'd0;
  localparam logic [StateCodeW-1:0] BS_SEARCHING = 3'd1;
  localparam logic [StateCodeW-1:0] BS_LOCKED    = 3'd2;
  localparam logic [StateCodeW-1:0] BS_FALLBACK  = 3'd3;
  localparam logic [StateCodeW-1:0] BS_RETRY     = 3'd4;

  typedef enum logic [4:0] {
    ST_IDLE      = 5'b00001,
    ST_SEARCHING = 5'b00010,
    ST_LOCKED    = 5'b00100,
    ST_FALLBACK  = 5'b01000,
    ST_RETRY     = 5'b10000
  } ctrl_state_t;

  typedef struct packed {
    logic             op;
    logic [TimeW-1:0] now_ms;
    logic             beacon_seen;
    logic [MacW-1:0]  mac_class_b_state;
  } in_item_t;

  typedef struct packed {
    logic [StateCodeW-1:0] beacon_state;
    logic                  multicast_request;
    logic                  time_request;
    logic                  fell_back;
  } result_t;

  function automatic logic [StateCodeW-1:0] state_code(input ctrl_state_t st);
    logic [StateCodeW-1:0] code;
    begin
      unique case (st)
        ST_SEARCHING: code = BS_SEARCHING;
        ST_LOCKED:    code = BS_LOCKED;
        ST_FALLBACK:  code = BS_FALLBACK;
        ST_RETRY:     code = BS_RETRY;
        default:      code = BS_IDLE;
      endcase
      return code;
    end
  endfunction

endpackage

`default_nettype wire

### sv/beacon_acquisition_control.sv
// ----------------------------------------------------------------------------
// beacon_acquisition_control
// An accepted item is held in the input register, then in the result register.
// Throughput: one item per cycle while out_stall is low; one pass of next-state
//   logic (two 32-bit subtract-compares) between input and result registers.
// Reset: synchronous, active low; control state idle, timers and multicast
//   flag cleared, timeout 130000 ms and retry interval 300000 ms.
// ----------------------------------------------------------------------------
`default_nettype none

module beacon_acquisition_control (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  // configuration write port
  input  wire logic                            cfg_wr_en,
  input  wire logic [bac_pkg::CfgIndexW-1:0]   cfg_index,
  input  wire logic [bac_pkg::CfgDataW-1:0]    cfg_wdata,
  // input item channel
  input  wire logic                            in_valid,
  output logic                                 in_stall,
  input  wire logic                            in_op,
  input  wire logic [bac_pkg::TimeW-1:0]       in_now_ms,
  input  wire logic                            in_beacon_seen,
  input  wire logic [bac_pkg::MacW-1:0]        in_mac_class_b_state,
  // result item channel
  output logic                                 out_valid,
  input  wire logic                            out_stall,
  output logic [bac_pkg::StateCodeW-1:0]       out_beacon_state,
  output logic                                 out_multicast_request,
  output logic                                 out_time_request,
  output logic                                 out_fell_back
);
  import bac_pkg::*;

  in_item_t in_item;
  in_item_t s1_item;
  logic     s1_valid;
  logic     advance;
  logic     fire;
  result_t  step_result;
  result_t  out_result;

  // Pack the input fields into one item
  assign in_item.op                = in_op;
  assign in_item.now_ms            = in_now_ms;
  assign in_item.beacon_seen       = in_beacon_seen;
  assign in_item.mac_class_b_state = in_mac_class_b_state;

  // Input register: takes a new item when empty or when the result register moves
  bac_in_stage u_in (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .advance  (advance),
    .s1_valid (s1_valid),
    .s1_item  (s1_item)
  );

  // Commit the state update only when the registered item moves on
  assign fire = s1_valid && advance;

  bac_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .fire      (fire),
    .item      (s1_item),
    .result    (step_result)
  );

  // Result register: parts the consumer's stall from the state machine
  bac_out_stage u_out (
    .clk        (clk),
    .rst_n      (rst_n),
    .s1_valid   (s1_valid),
    .result     (step_result),
    .advance    (advance),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .out_result (out_result)
  );

  assign out_beacon_state      = out_result.beacon_state;
  assign out_multicast_request = out_result.multicast_request;
  assign out_time_request      = out_result.time_request;
  assign out_fell_back         = out_result.fell_back;

  // Fallback entry is always reported with the fallback state
  a_fell_state : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_fell_back |-> out_beacon_state == BS_FALLBACK)
    else $error("fell_back without fallback state");

  // A time request only comes with entry into retry
  a_time_state : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_time_request |-> out_beacon_state == BS_RETRY)
    else $error("time_request outside retry");

  // Multicast set-up is only asked for while locked
  a_mc_state : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_multicast_request |-> out_beacon_state == BS_LOCKED)
    else $error("multicast_request outside locked");

  // Input side stalls only when the input register holds a blocked item
  a_stall_cause : assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid && out_valid && out_stall)
    else $error("input stalled without a blocked item");

  // A result held under stall keeps its fields
  a_hold : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result))
    else $error("held result changed");

endmodule

`default_nettype wire

### sv/bac_in_stage.sv
// ----------------------------------------------------------------------------
// bac_in_stage
// Input register: captures one item per cycle whenever it is empty or moving.
// ----------------------------------------------------------------------------
`default_nettype none

module bac_in_stage (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire bac_pkg::in_item_t in_item,
  input  wire logic              advance,
  output logic                   s1_valid,
  output bac_pkg::in_item_t      s1_item
);
  import bac_pkg::*;

  logic     valid_r;
  logic     valid_nxt;
  logic     load;
  in_item_t item_r;

  // Take a new item when the register is empty or its item moves on;
  // hold the item while the next stage is blocked
  assign load      = advance || !valid_r;
  assign in_stall  = !load;
  assign valid_nxt = load ? in_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (load && in_valid) begin
      item_r <= in_item;
    end
  end

  assign s1_valid = valid_r;
  assign s1_item  = item_r;

endmodule

`default_nettype wire

### sv/bac_ctrl.sv
// ----------------------------------------------------------------------------
// bac_ctrl
// Acquisition state machine, its timers and the configuration registers.
// ----------------------------------------------------------------------------
`default_nettype none

module bac_ctrl (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              cfg_wr_en,
  input  wire logic [bac_pkg::CfgIndexW-1:0]     cfg_index,
  input  wire logic [bac_pkg::CfgDataW-1:0]      cfg_wdata,
  input  wire logic                              fire,
  input  wire bac_pkg::in_item_t                 item,
  output bac_pkg::result_t                       result
);
  import bac_pkg::*;

  ctrl_state_t        state_r, state_nxt;
  logic [TimeW-1:0]   phase_start_r, phase_start_nxt;
  logic [TimeW-1:0]   next_retry_r, next_retry_nxt;
  logic               mc_done_r, mc_done_nxt;
  logic [TimeW-1:0]   timeout_r;
  logic [RetryW-1:0]  interval_r;

  logic [TimeW-1:0]   phase_age;
  logic [TimeW-1:0]   retry_delta;
  logic               timed_out;
  logic               retry_due;
  logic               mac_completed;
  logic               mc_req;
  logic               time_req;
  logic               fell;

  assign phase_age     = item.now_ms - phase_start_r;
  assign retry_delta   = item.now_ms - next_retry_r;
  assign timed_out     = phase_age > timeout_r;
  assign retry_due     = !retry_delta[TimeW-1];
  assign mac_completed = item.mac_class_b_state == MAC_COMPLETED;

  always_comb begin
    state_nxt       = state_r;
    phase_start_nxt = phase_start_r;
    next_retry_nxt  = next_retry_r;
    mc_done_nxt     = mc_done_r;
    mc_req          = 1'b0;
    time_req        = 1'b0;
    fell            = 1'b0;
    if (item.op == OP_START) begin
      state_nxt       = ST_SEARCHING;
      phase_start_nxt = item.now_ms;
      mc_done_nxt     = 1'b0;
    end else begin
      unique case (state_r)
        ST_SEARCHING, ST_RETRY: begin
          if (item.beacon_seen) begin
            state_nxt = ST_LOCKED;
            // retry clears the done flag before locking
            mc_req      = mac_completed && (state_r == ST_RETRY || !mc_done_r);
            mc_done_nxt = (state_r == ST_RETRY ? 1'b0 : mc_done_r) | mc_req;
          end else if (item.mac_class_b_state == MAC_FAILED || timed_out) begin
            state_nxt      = ST_FALLBACK;
            next_retry_nxt = item.now_ms + {1'b0, interval_r};
            fell           = 1'b1;
          end
        end
        ST_LOCKED: begin
          mc_req      = mac_completed && !mc_done_r;
          mc_done_nxt = mc_done_r | mc_req;
        end
        ST_FALLBACK: begin
          if (item.beacon_seen) begin
            state_nxt   = ST_LOCKED;
            mc_req      = mac_completed;
            mc_done_nxt = mac_completed;
          end else if (retry_due) begin
            state_nxt       = ST_RETRY;
            phase_start_nxt = item.now_ms;
            time_req        = 1'b1;
          end
        end
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= ST_IDLE;
      phase_start_r <= '0;
      next_retry_r  <= '0;
      mc_done_r     <= 1'b0;
    end else if (fire) begin
      state_r       <= state_nxt;
      phase_start_r <= phase_start_nxt;
      next_retry_r  <= next_retry_nxt;
      mc_done_r     <= mc_done_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      timeout_r  <= SearchTimeoutReset;
      interval_r <= RetryIntervalReset;
    end else if (cfg_wr_en) begin
      if (cfg_index == CFG_SEARCH_TIMEOUT) begin
        timeout_r <= cfg_wdata[TimeW-1:0];
      end
      if (cfg_index == CFG_RETRY_INTERVAL) begin
        interval_r <= cfg_wdata[RetryW-1:0];
      end
    end
  end

  assign result.beacon_state      = state_code(state_nxt);
  assign result.multicast_request = mc_req;
  assign result.time_request      = time_req;
  assign result.fell_back         = fell;

endmodule

`default_nettype wire

### sv/bac_out_stage.sv
// ----------------------------------------------------------------------------
// bac_out_stage
// Result register: holds a result until the consumer takes it.
// ----------------------------------------------------------------------------
`default_nettype none

module bac_out_stage (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             s1_valid,
  input  wire bac_pkg::result_t result,
  output logic                  advance,
  output logic                  out_valid,
  input  wire logic             out_stall,
  output bac_pkg::result_t      out_result
);
  import bac_pkg::*;

  logic    valid_r;
  logic    valid_nxt;
  result_t result_r;

  assign advance   = !valid_r || !out_stall;
  assign valid_nxt = advance ? s1_valid : valid_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (advance && s1_valid) begin
      result_r <= result;
    end
  end

  assign out_valid  = valid_r;
  assign out_result = result_r;

endmodule

`default_nettype wire

### sim/tb_beacon_acquisition_control.sv
// ----------------------------------------------------------------------------
// tb_beacon_acquisition_control
// Self-checking bench for the beacon acquisition controller. A queue of
// commands feeds a falling-edge driver; a rising-edge monitor runs an
// in-bench state tracker on every accepted item and checks each status
// result against it. Directed wrap and boundary cases run first, then random
// sessions under several timeout and retry settings, with random idling on
// both channels.
// ----------------------------------------------------------------------------
module tb_beacon_acquisition_control;
  timeunit 1ns;
  timeprecision 1ps;

  import bac_pkg::*;

  localparam int unsigned HalfPeriodNs = 10;
  localparam int unsigned RunLimitNs   = 5_000_000;
  localparam int unsigned ItemsPerPhase = 380;
  localparam int unsigned IdlePct      = 6;

  // Register slots past the defined list; writes there must be dropped.
  localparam logic [CfgIndexW-1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [CfgIndexW-1:0] CFG_SPARE_HI = 2'd3;

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  logic                  cfg_wr_en = 1'b0;
  logic [CfgIndexW-1:0]  cfg_index = '0;
  logic [CfgDataW-1:0]   cfg_wdata = '0;

  logic                  in_valid             = 1'b0;
  logic                  in_stall;
  logic                  in_op                = OP_TICK;
  logic [TimeW-1:0]      in_now_ms            = '0;
  logic                  in_beacon_seen       = 1'b0;
  logic [MacW-1:0]       in_mac_class_b_state = '0;

  logic                  out_valid;
  logic                  out_stall = 1'b0;
  logic [StateCodeW-1:0] out_beacon_state;
  logic                  out_multicast_request;
  logic                  out_time_request;
  logic                  out_fell_back;

  beacon_acquisition_control dut (
    .clk                   (clk),
    .rst_n                 (rst_n),
    .cfg_wr_en             (cfg_wr_en),
    .cfg_index             (cfg_index),
    .cfg_wdata             (cfg_wdata),
    .in_valid              (in_valid),
    .in_stall              (in_stall),
    .in_op                 (in_op),
    .in_now_ms             (in_now_ms),
    .in_beacon_seen        (in_beacon_seen),
    .in_mac_class_b_state  (in_mac_class_b_state),
    .out_valid             (out_valid),
    .out_stall             (out_stall),
    .out_beacon_state      (out_beacon_state),
    .out_multicast_request (out_multicast_request),
    .out_time_request      (out_time_request),
    .out_fell_back         (out_fell_back)
  );

  always #(HalfPeriodNs) clk = ~clk;

  // Commands waiting for the driver, and status results owed by the block.
  in_item_t    cmd_backlog[$];
  result_t     expected_status[$];
  int unsigned mismatch_count = 0;
  bit          quiet = 1'b0;   // suppress idling on both channels
  bit          in_took = 1'b0; // the input item was taken at the last rising edge

  in_item_t    next_cmd;
  in_item_t    caught_cmd;
  result_t     caught_status;
  result_t     want_status;

  // --------------------------------------------------------------------------
  // Acquisition tracker: mirrors the block's state and its two registers.
  // --------------------------------------------------------------------------
  logic [StateCodeW-1:0] trk_state;
  logic [TimeW-1:0]      trk_phase_start;
  logic [TimeW-1:0]      trk_retry_at;
  logic                  trk_mc_done;
  logic [TimeW-1:0]      trk_timeout;
  logic [RetryW-1:0]     trk_interval;

  // Raise the multicast request once per lock, when the MAC reports completed.
  function automatic logic claim_multicast(input logic [MacW-1:0] mac);
    if (trk_mc_done || mac != MAC_COMPLETED) return 1'b0;
    trk_mc_done = 1'b1;
    return 1'b1;
  endfunction

  function automatic result_t track_acquisition(input in_item_t cmd);
    result_t          res;
    logic [TimeW-1:0] since_phase;
    logic [TimeW-1:0] past_retry;
    res = '0;
    // Both differences wrap modulo 2^32, as the block's own arithmetic does.
    since_phase = cmd.now_ms - trk_phase_start;
    past_retry  = cmd.now_ms - trk_retry_at;
    if (cmd.op == OP_START) begin
      // A start wins from any state and re-arms the multicast request.
      trk_state       = BS_SEARCHING;
      trk_phase_start = cmd.now_ms;
      trk_mc_done     = 1'b0;
    end else begin
      case (trk_state)
        BS_SEARCHING, BS_RETRY: begin
          if (cmd.beacon_seen) begin
            // Only a lock out of retry clears the flag; a start already did
            // so for a lock out of searching.
            if (trk_state == BS_RETRY) trk_mc_done = 1'b0;
            trk_state = BS_LOCKED;
            res.multicast_request = claim_multicast(cmd.mac_class_b_state);
          end else if (cmd.mac_class_b_state == MAC_FAILED || since_phase > trk_timeout) begin
            trk_state     = BS_FALLBACK;
            trk_retry_at  = cmd.now_ms + {1'b0, trk_interval};
            res.fell_back = 1'b1;
          end
        end
        BS_LOCKED: begin
          res.multicast_request = claim_multicast(cmd.mac_class_b_state);
        end
        BS_FALLBACK: begin
          if (cmd.beacon_seen) begin
            trk_state   = BS_LOCKED;
            trk_mc_done = 1'b0;
            res.multicast_request = claim_multicast(cmd.mac_class_b_state);
          end else if (!past_retry[TimeW-1]) begin
            // Retry time reached when the wrapped difference is below half range.
            trk_state        = BS_RETRY;
            trk_phase_start  = cmd.now_ms;
            res.time_request = 1'b1;
          end
        end
        default: ; // idle ticks change nothing
      endcase
    end
    res.beacon_state = trk_state;
    return res;
  endfunction

  task automatic report_field(input string name, input logic [31:0] want,
                              input logic [31:0] got);
    $display("%0t ns: %s expected %0d, got %0d", $time, name, want, got);
    mismatch_count++;
  endtask

  // --------------------------------------------------------------------------
  // Driver: present the next command at the falling edge once the previous
  // one was taken; hold a stalled item unchanged.
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
    end else if (!in_valid || in_took) begin
      if (cmd_backlog.size() != 0 && (quiet || $urandom_range(99) >= IdlePct)) begin
        next_cmd             = cmd_backlog.pop_front();
        in_op                <= next_cmd.op;
        in_now_ms            <= next_cmd.now_ms;
        in_beacon_seen       <= next_cmd.beacon_seen;
        in_mac_class_b_state <= next_cmd.mac_class_b_state;
        in_valid             <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // Result side back-pressure: stall at random, never while quiet.
  always @(negedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
    end else begin
      out_stall <= !quiet && ($urandom_range(99) < IdlePct);
    end
  end

  // --------------------------------------------------------------------------
  // Monitor: track register writes, check each taken result against the
  // oldest expectation, then advance the tracker on each taken item.
  // --------------------------------------------------------------------------
  always @(posedge clk) begin
    in_took = in_valid && !in_stall;
    if (!rst_n) begin
      trk_state       = BS_IDLE;
      trk_phase_start = '0;
      trk_retry_at    = '0;
      trk_mc_done     = 1'b0;
      trk_timeout     = SearchTimeoutReset;
      trk_interval    = RetryIntervalReset;
    end else begin
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_SEARCH_TIMEOUT: trk_timeout  = cfg_wdata;
          CFG_RETRY_INTERVAL: trk_interval = cfg_wdata[RetryW-1:0];
          default: ; // drop writes past the register list
        endcase
      end
      if (out_valid && !out_stall) begin
        caught_status.beacon_state      = out_beacon_state;
        caught_status.multicast_request = out_multicast_request;
        caught_status.time_request      = out_time_request;
        caught_status.fell_back         = out_fell_back;
        if (expected_status.size() == 0) begin
          $display("%0t ns: unexpected result, expected none, got state %0d", $time,
                   out_beacon_state);
          mismatch_count++;
        end else begin
          want_status = expected_status.pop_front();
          if (caught_status.beacon_state !== want_status.beacon_state)
            report_field("beacon_state", 32'(want_status.beacon_state),
                         32'(caught_status.beacon_state));
          if (caught_status.multicast_request !== want_status.multicast_request)
            report_field("multicast_request", 32'(want_status.multicast_request),
                         32'(caught_status.multicast_request));
          if (caught_status.time_request !== want_status.time_request)
            report_field("time_request", 32'(want_status.time_request),
                         32'(caught_status.time_request));
          if (caught_status.fell_back !== want_status.fell_back)
            report_field("fell_back", 32'(want_status.fell_back),
                         32'(caught_status.fell_back));
        end
      end
      if (in_took) begin
        caught_cmd.op                = in_op;
        caught_cmd.now_ms            = in_now_ms;
        caught_cmd.beacon_seen       = in_beacon_seen;
        caught_cmd.mac_class_b_state = in_mac_class_b_state;
        expected_status.push_back(track_acquisition(caught_cmd));
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  task automatic queue_cmd(input logic op, input logic [TimeW-1:0] now_ms,
                           input logic seen, input logic [MacW-1:0] mac);
    in_item_t cmd;
    cmd.op                = op;
    cmd.now_ms            = now_ms;
    cmd.beacon_seen       = seen;
    cmd.mac_class_b_state = mac;
    cmd_backlog.push_back(cmd);
  endtask

  // Mostly well-formed sessions: a start, then ticks on a rising clock with
  // steps near the timeout and retry boundaries; some noise with random time.
  task automatic queue_sessions(input int unsigned count, input logic [TimeW-1:0] tmo,
                                input logic [RetryW-1:0] interval);
    logic [TimeW-1:0] clock_ms;
    logic [TimeW-1:0] step;
    logic [TimeW-1:0] span;
    logic [MacW-1:0]  mac;
    int unsigned      pick;
    int unsigned      roll;
    clock_ms = $urandom;
    span     = (tmo > 32'h0010_0000) ? 32'h0004_0000 : (tmo >> 2);
    for (int unsigned k = 0; k < count; k++) begin
      pick = $urandom_range(99);
      if (pick < 4) begin
        queue_cmd(1'($urandom_range(1)), $urandom, 1'($urandom_range(1)),
                  3'($urandom_range(7)));
      end else if (pick < 10) begin
        queue_cmd(OP_START, clock_ms, 1'($urandom_range(1)), 3'($urandom_range(7)));
      end else begin
        roll = $urandom_range(99);
        if (roll < 45)      step = $urandom_range(span);
        else if (roll < 60) step = $urandom_range(3);
        else if (roll < 75) step = tmo - 1 + $urandom_range(2);
        else if (roll < 90) step = {1'b0, interval} - 1 + $urandom_range(2);
        else                step = $urandom;
        clock_ms = clock_ms + step;
        roll = $urandom_range(99);
        if (roll < 5)       mac = MAC_FAILED;
        else if (roll < 13) mac = MAC_COMPLETED;
        else if (roll < 16) mac = 3'($urandom_range(7, 5));
        else                mac = 3'($urandom_range(2));
        queue_cmd(OP_TICK, clock_ms, $urandom_range(99) < 7, mac);
      end
    end
  endtask

  // Hold until every command is taken and every result has come back.
  task automatic wait_drained();
    do begin
      @(posedge clk);
      #1;
    end while (cmd_backlog.size() != 0 || in_valid || expected_status.size() != 0);
  endtask

  task automatic write_reg(input logic [CfgIndexW-1:0] idx, input logic [CfgDataW-1:0] data);
    @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
  endtask

  initial begin
    logic [TimeW-1:0]    t0;
    logic [TimeW-1:0]    retry_at;
    logic [TimeW-1:0]    tmo;
    logic [CfgDataW-1:0] retry_word;

    // Directed part under the reset timeout (130000) and retry (300000).
    t0 = 32'hFFFF_FFF0;
    queue_cmd(OP_TICK, 32'hFFFF_FFFF, 1'b1, 3'd7);        // idle ignores all fields
    queue_cmd(OP_TICK, '0, 1'b0, MAC_COMPLETED);
    queue_cmd(OP_START, t0, 1'b1, MAC_COMPLETED);         // start ignores beacon and MAC
    queue_cmd(OP_TICK, t0 + 32'd130000, 1'b0, '0);        // exactly at timeout: stay
    queue_cmd(OP_TICK, t0 + 32'd130001, 1'b0, 3'd6);      // past timeout across the wrap
    retry_at = t0 + 32'd130001 + 32'd300000;
    queue_cmd(OP_TICK, retry_at - 1, 1'b0, MAC_COMPLETED); // one short of retry
    queue_cmd(OP_TICK, retry_at + 32'h8000_0000, 1'b0, '0); // half range: not reached
    queue_cmd(OP_TICK, retry_at, 1'b0, '0);               // retry, time request
    queue_cmd(OP_TICK, retry_at + 5, 1'b0, MAC_FAILED);   // failure in retry
    retry_at = retry_at + 5 + 32'd300000;
    queue_cmd(OP_TICK, retry_at - 1000, 1'b1, MAC_COMPLETED); // lock out of fallback
    queue_cmd(OP_TICK, retry_at, 1'b1, MAC_COMPLETED);    // multicast only once
    queue_cmd(OP_START, '0, 1'b0, '0);                    // restart from locked
    queue_cmd(OP_TICK, 32'd5, 1'b0, 3'd5);                // unused MAC codes
    queue_cmd(OP_TICK, 32'd6, 1'b0, 3'd7);
    queue_cmd(OP_TICK, 32'd7, 1'b1, 3'd2);                // lock without completion
    queue_cmd(OP_TICK, 32'd8, 1'b0, MAC_COMPLETED);       // later completion in lock
    queue_cmd(OP_START, 32'd9, 1'b1, MAC_FAILED);
    queue_cmd(OP_TICK, 32'd10, 1'b1, MAC_COMPLETED);      // lock and request at once
    queue_cmd(OP_START, 32'd20, 1'b0, '0);
    queue_cmd(OP_TICK, 32'd21, 1'b0, MAC_FAILED);         // failure in searching
    queue_cmd(OP_TICK, 32'd300021, 1'b0, '0);             // retry
    queue_cmd(OP_TICK, 32'd430022, 1'b1 ^ 1'b1, '0);      // elapsed 130001: fall back
    queue_cmd(OP_TICK, 32'd730022, 1'b0, '0);             // retry again
    queue_cmd(OP_TICK, 32'd730023, 1'b1, MAC_COMPLETED);  // lock out of retry

    repeat (8) @(posedge clk);
    @(negedge clk) rst_n <= 1'b1;
    wait_drained();

    // Random phases: minimum, maximum, zero timeout with a masked retry word,
    // then random settings. One phase runs with no idling at all.
    for (int unsigned phase = 0; phase < 5; phase++) begin
      case (phase)
        0: begin tmo = 32'd1;     retry_word = 32'd1;          end
        1: begin tmo = '1;        retry_word = 32'h7FFF_FFFF;  end
        2: begin tmo = '0;        retry_word = 32'h8000_0005;  end
        3: begin
          tmo        = $urandom_range(200_000, 1000);
          retry_word = $urandom_range(400_000, 1000);
        end
        default: begin tmo = $urandom; retry_word = $urandom; end
      endcase
      write_reg(CFG_SEARCH_TIMEOUT, tmo);
      write_reg(CFG_RETRY_INTERVAL, retry_word);
      if (phase == 2) begin
        write_reg(CFG_SPARE_LO, $urandom);
        write_reg(CFG_SPARE_HI, $urandom);
      end
      quiet = (phase == 3);
      @(posedge clk);
      queue_sessions(ItemsPerPhase, tmo, retry_word[RetryW-1:0]);
      wait_drained();
    end
    quiet = 1'b0;

    // Let any stray result surface before the verdict.
    repeat (4) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

  // Watchdog
  initial begin
    #(RunLimitNs);
    $display("SCOREBOARD MISMATCH");
    $finish;
  end

endmodule
